/* rtl/core/prw_pkg.sv */
// Package for the polyline route walker: request/result payload structs,
// table row layout, mode codes and fixed-point constants.
// No dependencies.
`timescale 1ns / 1ps

package prw_pkg;

  localparam int FRAC_BITS = 12;
  localparam int LEN_W     = 15;
  localparam int WHOLE_W   = 32 - FRAC_BITS;

  localparam logic [LEN_W-1:0] LEN_END  = 15'h7FFF;
  localparam logic [LEN_W-1:0] LEN_LOOP = 15'h7FFE;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_MOVE = 2'd1;
  localparam logic [1:0] MODE_SET  = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         row_index;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [15:0] step_x;
    logic signed [15:0] step_y;
    logic signed [15:0] step_z;
    logic [LEN_W-1:0]   seg_length;
    logic signed [31:0] speed;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [7:0]         segment;
    logic signed [31:0] in_segment_count;
    logic signed [31:0] travelled;
  } out_t;

  // One row of the geometry memory.
  typedef struct packed {
    logic [31:0] start_x;
    logic [31:0] start_y;
    logic [31:0] start_z;
    logic [15:0] step_x;
    logic [15:0] step_y;
    logic [15:0] step_z;
  } geo_t;

endpackage

/* rtl/core/polyline_route_walker.sv */
// Polyline route walker top level: segment tables in two synchronous
// memories, a walk sequencer and a shared position multiplier.
// Depends on prw_pkg.
`timescale 1ns / 1ps

// Sequence: an item that does not walk (unused mode, zero speed) passes
//   S_MX, S_MY and S_MZ before out_valid rises; a load first passes S_LD
//   (write) and S_REREAD (re-read). A move or set first walks in S_FWD or
//   S_BWD, segment by segment; a forward crossing that lands inside its new
//   segment ends the walk in the same cycle.
//   A backward wrap at segment 0 adds a scan of the length memory from row 0
//   to the first marker row, one row per cycle (length-port read rate).
// Requests: one at a time; the next is taken while the result waits in the
//   output register.
// Reset: synchronous, active low; clears segment, count and distance sum.
//   Table memories are not cleared and are undefined until loaded.
module polyline_route_walker #(
  parameter int MAX_ROWS = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  prw_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output prw_pkg::out_t out_data
);

  localparam int AW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int FB    = prw_pkg::FRAC_BITS;
  localparam int LW    = prw_pkg::LEN_W;
  localparam int WW    = prw_pkg::WHOLE_W;
  localparam logic [AW-1:0] SEG_LAST = AW'(MAX_ROWS - 1);

  typedef enum logic [3:0] {
    S_IDLE,    // waiting for a request
    S_LD,      // write table row, fix distance sum
    S_REREAD,  // geometry re-read after a write
    S_FWD,     // forward walk, one segment a cycle
    S_BWD,     // backward walk, one segment a cycle
    S_SCAN,    // search for the loop marker from row 0
    S_MX,      // position x
    S_MY,      // position y
    S_MZ       // position z, hand result to output register
  } state_t;

  // Length in units to 20.12 fixed point.
  function automatic logic [31:0] len_fx(input logic [LW-1:0] l);
    len_fx = {{(32 - LW - FB){1'b0}}, l, {FB{1'b0}}};
  endfunction

  // --------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------
  state_t          state_r, state_nxt;
  logic [AW-1:0]   seg_r, seg_nxt;
  logic [31:0]     count_r, count_nxt;
  logic [WW-1:0]   sum_r, sum_nxt;      // lengths of rows before seg_r
  logic            wrapped_r, wrapped_nxt;
  logic            moved_r, moved_nxt;
  logic            out_valid_r, out_valid_nxt;
  prw_pkg::in_t    req_r, req_nxt;
  prw_pkg::out_t   out_data_r, out_data_nxt;
  logic [31:0]     pos_x_r, pos_x_nxt;
  logic [31:0]     pos_y_r, pos_y_nxt;
  logic [AW-1:0]   m_r, m_nxt;          // scan row
  logic [WW-1:0]   acc_r, acc_nxt;      // scan: lengths of rows before m_r
  logic [LW-1:0]   prev_r, prev_nxt;    // scan: length of row m_r - 1

  // --------------------------------------------------------------------
  // Memories: lengths (two read ports), geometry (one read port)
  // --------------------------------------------------------------------
  logic [LW-1:0]   len_mem [MAX_ROWS];
  prw_pkg::geo_t   geo_mem [MAX_ROWS];
  logic [LW-1:0]   len_a_r, len_b_r;
  prw_pkg::geo_t   geo_r;
  logic [AW-1:0]   addr_a, addr_b, wr_addr;
  logic            tbl_we;

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      len_mem[wr_addr] <= req_r.seg_length;
      geo_mem[wr_addr] <= {req_r.start_x, req_r.start_y, req_r.start_z,
                           req_r.step_x, req_r.step_y, req_r.step_z};
    end
    len_a_r <= len_mem[addr_a];
    len_b_r <= len_mem[addr_b];
    geo_r   <= geo_mem[seg_nxt];
  end

  // --------------------------------------------------------------------
  // Datapath terms
  // --------------------------------------------------------------------
  logic [31:0]        in_row_ext, req_row_ext;
  logic               in_row_ok, req_row_ok;
  logic [AW-1:0]      in_row_addr;
  logic [WW-1:0]      whole;
  logic               seg_last;
  logic [LW-1:0]      fwd_nl;
  logic               fwd_gt;
  logic [31:0]        fwd_cnt;
  logic               fwd_cnt_lt;
  logic               fwd_moved;
  logic [31:0]        bwd_cnt;
  logic [31:0]        scan_cnt;
  logic signed [15:0] mul_step;
  logic signed [35:0] mul_full;
  logic [31:0]        prod;

  assign in_row_ext  = 32'(in_data.row_index);
  assign in_row_ok   = in_row_ext < 32'(MAX_ROWS);
  assign in_row_addr = in_row_ok ? in_row_ext[AW-1:0] : '0;
  assign req_row_ext = 32'(req_r.row_index);
  assign req_row_ok  = req_row_ext < 32'(MAX_ROWS);
  assign wr_addr     = req_row_ok ? req_row_ext[AW-1:0] : '0;

  // Whole units: arithmetic shift of the count.
  assign whole    = count_r[31:FB];
  assign seg_last = (seg_r == SEG_LAST);

  // Forward step: len_a_r is this segment, len_b_r the next one.
  assign fwd_nl     = seg_last ? prw_pkg::LEN_END : len_b_r;
  assign fwd_gt     = $signed(whole) > $signed({{(WW - LW){1'b0}}, len_a_r});
  assign fwd_cnt    = count_r - len_fx(len_a_r);
  assign fwd_cnt_lt = $signed(fwd_cnt) < $signed(len_fx(fwd_nl));
  assign fwd_moved  = moved_r | (len_a_r != '0);

  // Backward step: len_a_r is the previous segment.
  assign bwd_cnt  = count_r + len_fx(len_a_r);
  assign scan_cnt = count_r + len_fx(prev_r);

  // Shared multiplier, one axis per cycle; z waits in S_MZ while the output register is full.
  always_comb begin
    case (state_r)
      S_MX:    mul_step = $signed(geo_r.step_x);
      S_MY:    mul_step = $signed(geo_r.step_y);
      default: mul_step = $signed(geo_r.step_z);
    endcase
  end
  assign mul_full = mul_step * $signed(whole);
  assign prod     = mul_full[31:0];

  // --------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    seg_nxt       = seg_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    wrapped_nxt   = wrapped_r;
    moved_nxt     = moved_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    req_nxt       = req_r;
    out_data_nxt  = out_data_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    m_nxt         = m_r;
    acc_nxt       = acc_r;
    prev_nxt      = prev_r;
    tbl_we        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt     = in_data;
          wrapped_nxt = 1'b0;
          moved_nxt   = 1'b0;
          case (in_data.mode)
            prw_pkg::MODE_LOAD: state_nxt = S_LD;
            prw_pkg::MODE_MOVE,
            prw_pkg::MODE_SET: begin
              if (in_data.mode == prw_pkg::MODE_SET) begin
                count_nxt = in_data.speed;
                seg_nxt   = '0;
                sum_nxt   = '0;
              end else begin
                count_nxt = count_r + in_data.speed;
              end
              if (in_data.speed == '0) begin
                state_nxt = S_MX;
              end else if (in_data.speed[31]) begin
                state_nxt = S_BWD;
              end else begin
                state_nxt = S_FWD;
              end
            end
            default: state_nxt = S_MX;  // unused mode reports state
          endcase
        end
      end

      S_LD: begin
        // len_a_r holds the old length of the row
        tbl_we = req_row_ok;
        if (req_row_ok && (req_row_ext < 32'(seg_r))) begin
          sum_nxt = sum_r + WW'(req_r.seg_length) - WW'(len_a_r);
        end
        state_nxt = S_REREAD;
      end

      S_REREAD: state_nxt = S_MX;

      S_FWD: begin
        if (!fwd_gt || (fwd_nl == prw_pkg::LEN_END)) begin
          state_nxt = S_MX;
        end else begin
          count_nxt = fwd_cnt;
          moved_nxt = fwd_moved;
          if (fwd_nl == prw_pkg::LEN_LOOP) begin
            seg_nxt = '0;
            sum_nxt = '0;
            if (wrapped_r && !fwd_moved) begin
              state_nxt = S_MX;   // zero-length lap
            end else begin
              wrapped_nxt = 1'b1;
              moved_nxt   = 1'b0;
            end
          end else begin
            seg_nxt = seg_r + 1'b1;
            sum_nxt = sum_r + WW'(len_a_r);
            if (fwd_cnt_lt) state_nxt = S_MX;
          end
        end
      end

      S_BWD: begin
        if (!count_r[31]) begin
          state_nxt = S_MX;
        end else if (seg_r != '0) begin
          seg_nxt   = seg_r - 1'b1;
          count_nxt = bwd_cnt;
          sum_nxt   = sum_r - WW'(len_a_r);
          moved_nxt = moved_r | (len_a_r != '0);
        end else begin
          state_nxt = S_SCAN;
          m_nxt     = '0;
          acc_nxt   = '0;
          prev_nxt  = '0;
        end
      end

      S_SCAN: begin
        // len_a_r holds row m_r
        if (len_a_r inside {prw_pkg::LEN_LOOP, prw_pkg::LEN_END}) begin
          if ((m_r != '0) && (len_a_r == prw_pkg::LEN_LOOP) &&
              !(wrapped_r && !moved_r)) begin
            seg_nxt     = m_r - 1'b1;
            count_nxt   = scan_cnt;
            sum_nxt     = acc_r - WW'(prev_r);
            moved_nxt   = (prev_r != '0);
            wrapped_nxt = 1'b1;
            state_nxt   = S_BWD;
          end else begin
            state_nxt = S_MX;   // no usable loop: hold at segment 0
          end
        end else if (m_r == SEG_LAST) begin
          state_nxt = S_MX;
        end else begin
          acc_nxt  = acc_r + WW'(len_a_r);
          prev_nxt = len_a_r;
          m_nxt    = m_r + 1'b1;
        end
      end

      S_MX: begin
        pos_x_nxt = geo_r.start_x + prod;
        state_nxt = S_MY;
      end

      S_MY: begin
        pos_y_nxt = geo_r.start_y + prod;
        state_nxt = S_MZ;
      end

      S_MZ: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.pos_x            = pos_x_r;
          out_data_nxt.pos_y            = pos_y_r;
          out_data_nxt.pos_z            = geo_r.start_z + prod;
          out_data_nxt.segment          = 8'(seg_r);
          out_data_nxt.in_segment_count = count_r;
          out_data_nxt.travelled        = {sum_r, {FB{1'b0}}} + count_r;
          out_valid_nxt                 = 1'b1;
          state_nxt                     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Length read addresses follow the data the next state consumes.
  always_comb begin
    case (state_nxt)
      S_LD:    addr_a = in_row_addr;
      S_SCAN:  addr_a = m_nxt;
      S_BWD:   addr_a = (seg_nxt == '0) ? '0 : seg_nxt - 1'b1;
      default: addr_a = seg_nxt;
    endcase
    addr_b = (seg_nxt == SEG_LAST) ? '0 : seg_nxt + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seg_r       <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      wrapped_r   <= 1'b0;
      moved_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seg_r       <= seg_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      wrapped_r   <= wrapped_nxt;
      moved_r     <= moved_nxt;
      out_valid_r <= out_valid_nxt;
      req_r       <= req_nxt;
      out_data_r  <= out_data_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      m_r         <= m_nxt;
      acc_r       <= acc_nxt;
      prev_r      <= prev_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* bench/tb.sv */
// Self-checking bench for polyline_route_walker: a route tracker class predicts
// every result, and plain tasks drive random-gap requests and random-stall results.
// Depends on prw_pkg and polyline_route_walker.
`timescale 1ns / 1ps

module tb;

  localparam int ROWS = 256;
  // Walk iterations (segment crossings plus loop-marker scan rows) allowed per
  // request.
  localparam int COST_CAP = 300;
  // Mode code the block leaves unused; it only reports the current state.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  prw_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  prw_pkg::out_t out_data;

  // Tracks the route tables and the walker position, and holds the positions
  // the block still owes us, oldest first.
  class route_tracker;
    bit [31:0]     start_mem [ROWS][3];
    bit [31:0]     step_mem [ROWS][3];
    bit [14:0]     len_mem [ROWS];
    bit            loaded [ROWS];
    int            seg;
    bit [31:0]     count;
    bit            hit_blank;
    int            walk_cost;
    prw_pkg::out_t expected_positions[$];
    int            errors;

    function new();
      foreach (len_mem[i]) begin
        len_mem[i] = '0;
        loaded[i] = 0;
        for (int k = 0; k < 3; k++) begin
          start_mem[i][k] = '0;
          step_mem[i][k] = '0;
        end
      end
      seg = 0;
      count = '0;
      errors = 0;
    endfunction

    // Rows past the table read as an end marker.
    function int len_at(int i);
      if (i >= ROWS) return int'(prw_pkg::LEN_END);
      if (!loaded[i]) hit_blank = 1;
      return int'(len_mem[i]);
    endfunction

    function void walk_ahead();
      bit wrapped;
      bit moved;
      int co;
      int whole;
      wrapped = 0;
      moved = 0;
      forever begin
        co = len_at(seg);
        whole = $signed(count) >>> prw_pkg::FRAC_BITS;
        if (whole <= co) break;
        if (len_at(seg + 1) == int'(prw_pkg::LEN_END)) break;
        count -= co << prw_pkg::FRAC_BITS;
        if (co != 0) moved = 1;
        seg++;
        walk_cost++;
        if (len_at(seg) == int'(prw_pkg::LEN_LOOP)) begin
          seg = 0;
          // a full lap that never shortened the count: give up at row 0
          if (wrapped && !moved) break;
          wrapped = 1;
          moved = 0;
        end else if ($signed(count) < (len_at(seg) << prw_pkg::FRAC_BITS)) begin
          break;
        end
      end
    endfunction

    function void walk_back();
      bit wrapped;
      bit moved;
      int co;
      int m;
      wrapped = 0;
      moved = 0;
      forever begin
        if ($signed(count) >= 0) break;
        if (seg > 0) begin
          seg--;
          walk_cost++;
          co = len_at(seg);
          count += co << prw_pkg::FRAC_BITS;
          if (co != 0) moved = 1;
          if ($signed(count) >= 0) break;
        end else begin
          // find the first marker row; only a loop marker past row 0 lets us wrap
          m = 0;
          while (m < ROWS && len_at(m) < int'(prw_pkg::LEN_LOOP)) m++;
          walk_cost += m + 1;
          if (len_at(m) != int'(prw_pkg::LEN_LOOP) || m == 0) break;
          if (wrapped && !moved) break;
          wrapped = 1;
          moved = 0;
          seg = m - 1;
          co = len_at(seg);
          count += co << prw_pkg::FRAC_BITS;
          if (co != 0) moved = 1;
        end
      end
    endfunction

    function void advance(bit [31:0] spd);
      count += spd;
      if (spd == 0) return;
      if (spd[31]) walk_back();
      else walk_ahead();
    endfunction

    function prw_pkg::out_t next_position(prw_pkg::in_t req);
      prw_pkg::out_t res;
      int            whole;
      bit [31:0]     len_sum;
      case (req.mode)
        prw_pkg::MODE_LOAD: begin
          start_mem[req.row_index][0] = req.start_x;
          start_mem[req.row_index][1] = req.start_y;
          start_mem[req.row_index][2] = req.start_z;
          step_mem[req.row_index][0] = {{16{req.step_x[15]}}, req.step_x};
          step_mem[req.row_index][1] = {{16{req.step_y[15]}}, req.step_y};
          step_mem[req.row_index][2] = {{16{req.step_z[15]}}, req.step_z};
          len_mem[req.row_index] = req.seg_length;
          loaded[req.row_index] = 1;
        end
        prw_pkg::MODE_MOVE: advance(req.speed);
        prw_pkg::MODE_SET: begin
          seg = 0;
          count = '0;
          advance(req.speed);
        end
        default: ;
      endcase
      if (!loaded[seg]) hit_blank = 1;
      whole = $signed(count) >>> prw_pkg::FRAC_BITS;
      res.pos_x = start_mem[seg][0] + step_mem[seg][0] * whole;
      res.pos_y = start_mem[seg][1] + step_mem[seg][1] * whole;
      res.pos_z = start_mem[seg][2] + step_mem[seg][2] * whole;
      len_sum = '0;
      for (int i = 0; i < seg; i++) len_sum += len_at(i);
      res.segment = seg[7:0];
      res.in_segment_count = count;
      res.travelled = (len_sum << prw_pkg::FRAC_BITS) + count;
      return res;
    endfunction

    // Dry run: would this request read a row never loaded, or walk too long?
    function bit too_costly(prw_pkg::in_t req);
      bit [31:0] keep_start [ROWS][3];
      bit [31:0] keep_step [ROWS][3];
      bit [14:0] keep_len [ROWS];
      bit        keep_loaded [ROWS];
      int        keep_seg;
      bit [31:0] keep_count;
      bit        risky;
      keep_start = start_mem;
      keep_step = step_mem;
      keep_len = len_mem;
      keep_loaded = loaded;
      keep_seg = seg;
      keep_count = count;
      hit_blank = 0;
      walk_cost = 0;
      void'(next_position(req));
      risky = hit_blank || walk_cost > COST_CAP;
      start_mem = keep_start;
      step_mem = keep_step;
      len_mem = keep_len;
      loaded = keep_loaded;
      seg = keep_seg;
      count = keep_count;
      return risky;
    endfunction

    function void note_request(prw_pkg::in_t req);
      expected_positions.push_back(next_position(req));
    endfunction

    function void compare_field(string name, bit [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t %s: expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(prw_pkg::out_t got);
      prw_pkg::out_t want;
      if (expected_positions.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual %h", $time, got);
        return;
      end
      want = expected_positions.pop_front();
      compare_field("pos_x", want.pos_x, got.pos_x);
      compare_field("pos_y", want.pos_y, got.pos_y);
      compare_field("pos_z", want.pos_z, got.pos_z);
      compare_field("segment", 32'(want.segment), 32'(got.segment));
      compare_field("in_segment_count", want.in_segment_count, got.in_segment_count);
      compare_field("travelled", want.travelled, got.travelled);
    endfunction
  endclass

  route_tracker tracker = new();
  bit calm;        // no idling on either side while set
  int ready_hold;  // cycles the result side still stalls

  polyline_route_walker u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs; the slowest legal run is far shorter.
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: check each accepted result, then draw a random stall.
  // Signals are read right after the edge, so they hold their pre-edge values.
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      tracker.check_result(out_data);
      ready_hold = calm ? 0 : $urandom_range(0, 3);
    end else if (ready_hold > 0) begin
      ready_hold--;
    end
    out_ready <= (ready_hold == 0);
  end

  // Every field random; callers override what matters.
  function automatic prw_pkg::in_t rand_item();
    prw_pkg::in_t r;
    r.mode = 2'($urandom_range(0, 3));
    r.row_index = 8'($urandom_range(0, 255));
    r.start_x = $urandom;
    r.start_y = $urandom;
    r.start_z = $urandom;
    r.step_x = 16'($urandom_range(0, 65535));
    r.step_y = 16'($urandom_range(0, 65535));
    r.step_z = 16'($urandom_range(0, 65535));
    r.seg_length = 15'($urandom_range(0, 32767));
    r.speed = $urandom;
    return r;
  endfunction

  function automatic prw_pkg::in_t item(logic [1:0] mode, int row, int len,
                                        logic [31:0] spd);
    prw_pkg::in_t r;
    r = rand_item();
    r.mode = mode;
    r.row_index = row[7:0];
    r.seg_length = len[14:0];
    r.speed = spd;
    return r;
  endfunction

  // Speed in signed 20.12: mostly within span units either way, plus zero, pure
  // fractions and the odd full-range value.
  function automatic logic [31:0] pick_speed(int span);
    logic [31:0] mag;
    case ($urandom_range(0, 9))
      0: mag = '0;
      1: mag = $urandom;
      2: mag = $urandom_range(1, 4095);
      default: mag = $urandom_range(0, span * 4096);
    endcase
    if ($urandom_range(0, 1)) mag = -mag;
    return mag;
  endfunction

  function automatic prw_pkg::in_t draw_step(int span);
    prw_pkg::in_t r;
    r = rand_item();
    case ($urandom_range(0, 19))
      0, 1: r.mode = prw_pkg::MODE_LOAD;     // stray row write, any row, any length
      2: r.mode = MODE_SPARE;
      3, 4: begin
        r.mode = prw_pkg::MODE_SET;
        r.speed = $urandom_range(0, span * 4096);
      end
      5: begin
        r.mode = prw_pkg::MODE_SET;
        r.speed = pick_speed(span);
      end
      default: begin
        r.mode = prw_pkg::MODE_MOVE;
        r.speed = pick_speed(span);
      end
    endcase
    return r;
  endfunction

  // One request on the input channel, after a random gap; valid stays up
  // across back-to-back requests.
  task automatic send_request(prw_pkg::in_t req);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(req);
  endtask

  // Anything that would read an unloaded row or walk too far becomes a
  // return to the route start instead.
  task automatic issue(prw_pkg::in_t req);
    if (tracker.too_costly(req)) req = item(prw_pkg::MODE_SET, 0, 0, 0);
    send_request(req);
  endtask

  task automatic random_step(int span);
    prw_pkg::in_t r;
    int           tries;
    tries = 0;
    do begin
      r = draw_step(span);
      tries++;
    end while (tracker.too_costly(r) && tries < 8);
    issue(r);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (tracker.expected_positions.size() != 0) @(posedge clk);
  endtask

  // Rows 0..n_seg-1 as segments, a marker row after them, then back to start.
  task automatic build_route(int n_seg, bit looped, int len_hi, bit long_segs);
    int len;
    for (int r = 0; r < n_seg; r++) begin
      len = long_segs ? $urandom_range(1000, int'(prw_pkg::LEN_LOOP) - 1)
                      : $urandom_range(0, len_hi);
      issue(item(prw_pkg::MODE_LOAD, r, len, $urandom));
    end
    issue(item(prw_pkg::MODE_LOAD, n_seg,
               looped ? int'(prw_pkg::LEN_LOOP) : int'(prw_pkg::LEN_END), $urandom));
    issue(item(prw_pkg::MODE_SET, 0, 0, 0));
  endtask

  initial begin
    prw_pkg::in_t r;
    int           span;
    rst_n <= 0;
    in_valid <= 0;
    in_data <= '0;
    out_ready <= 0;
    calm = 0;
    ready_hold = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // --- directed part ---
    // Route: short row 0 with extreme start/step, a zero-length row, the
    // longest legal row, then a loop marker.
    r = item(prw_pkg::MODE_LOAD, 0, 2, 0);
    r.start_x = 32'h7FFF_FFFF;
    r.start_y = 32'h8000_0000;
    r.start_z = '0;
    r.step_x = 16'h7FFF;
    r.step_y = 16'h8000;
    r.step_z = 16'h0001;
    issue(r);
    issue(item(prw_pkg::MODE_LOAD, 1, 0, 0));
    issue(item(prw_pkg::MODE_LOAD, 2, int'(prw_pkg::LEN_LOOP) - 1, 0));
    issue(item(prw_pkg::MODE_LOAD, 3, int'(prw_pkg::LEN_LOOP), 0));
    issue(item(MODE_SPARE, 0, 0, $urandom));                  // unused mode
    issue(item(prw_pkg::MODE_MOVE, 0, 0, 0));                 // zero speed
    issue(item(prw_pkg::MODE_MOVE, 0, 0, 1));                 // one fraction LSB
    issue(item(prw_pkg::MODE_MOVE, 0, 0, 3 << 12));           // over the zero-length row
    issue(item(prw_pkg::MODE_MOVE, 0, 0, -(5 << 12)));        // backward wrap through the loop
    issue(item(prw_pkg::MODE_MOVE, 0, 0, 32'h7FFF_FFFF));     // count overflows
    issue(item(prw_pkg::MODE_MOVE, 0, 0, 32'h8000_0000));
    issue(item(prw_pkg::MODE_SET, 0, 0, 0));
    issue(item(prw_pkg::MODE_SET, 0, 0, 32'h7FFF_FFFF));      // many laps
    issue(item(prw_pkg::MODE_SET, 0, 0, -(1 << 12)));         // negative set wraps back
    // Same route closed by an end marker.
    issue(item(prw_pkg::MODE_LOAD, 3, int'(prw_pkg::LEN_END), 0));
    issue(item(prw_pkg::MODE_SET, 0, 0, 32'h7FFF_FFFF));      // runs into the end
    issue(item(prw_pkg::MODE_SET, 0, 0, -(1 << 12)));         // no loop: stays at row 0
    // Loop made of zero-length rows only.
    issue(item(prw_pkg::MODE_LOAD, 0, 0, 0));
    issue(item(prw_pkg::MODE_LOAD, 1, 0, 0));
    issue(item(prw_pkg::MODE_LOAD, 2, int'(prw_pkg::LEN_LOOP), 0));
    issue(item(prw_pkg::MODE_MOVE, 0, 0, 7 << 12));
    issue(item(prw_pkg::MODE_MOVE, 0, 0, -(9 << 12)));
    // Loop marker already in row 0.
    issue(item(prw_pkg::MODE_LOAD, 0, int'(prw_pkg::LEN_LOOP), 0));
    issue(item(prw_pkg::MODE_MOVE, 0, 0, -(1 << 12)));
    issue(item(prw_pkg::MODE_LOAD, 255, int'(prw_pkg::LEN_END), 0));
    drain();

    // --- random phases: short looped, short ended, long segments ---
    for (int p = 0; p < 3; p++) begin
      calm = (p == 1);
      case (p)
        0: begin
          build_route($urandom_range(4, 10), 1, 16, 0);
          span = 64;
        end
        1: begin
          build_route($urandom_range(2, 6), 0, 16, 0);
          span = 64;
        end
        default: begin
          build_route($urandom_range(2, 8), 1'($urandom_range(0, 1)), 0, 1);
          span = 400000;
        end
      endcase
      repeat (60) random_step(span);
      drain();  // sender holds off until every result is back
    end

    // --- whole table as one route, no marker: walking reaches the table end ---
    calm = 0;
    for (int row = 0; row < ROWS; row++)
      issue(item(prw_pkg::MODE_LOAD, row, $urandom_range(1, 3), $urandom));
    issue(item(prw_pkg::MODE_SET, 0, 0, 0));
    repeat (15) issue(item(prw_pkg::MODE_MOVE, 0, 0, $urandom_range(0, 200 * 4096)));
    repeat (40) random_step(120);

    drain();
    repeat (20) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* polyline_route_walker.f */
rtl/core/prw_pkg.sv
rtl/core/polyline_route_walker.sv
bench/tb.sv
